[hw/rtl/vas_pkg.sv]
// ----------------------------------------------------------------------------
// vas_pkg: shared definitions for the visual alignment servo
// constants, operation codes, status codes and controller/datapath structs
// ----------------------------------------------------------------------------
`default_nettype none

package vas_pkg;

  // default sizes
  localparam int ERR_BITS_DEF   = 12;
  localparam int TIMER_BITS_DEF = 16;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TOL_W     = 11;
  localparam int SPD_W     = 10;
  localparam int VEL_W     = 11;

  localparam logic [CFG_IDX_W-1:0] REG_TOL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 3'd4;

  localparam logic [TOL_W-1:0] TOL_RST     = 11'd25;
  localparam logic [CFG_W-1:0] DWELL_RST   = 16'd100;
  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd3500;
  localparam logic [CFG_W-1:0] GAIN_RST    = 16'd256;
  localparam logic [SPD_W-1:0] SPEED_RST   = 10'd350;

  // result status codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // datapath operations, one per controller step
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_IDLE  = 3'd0;
  localparam logic [OP_W-1:0] OP_SQX   = 3'd1;
  localparam logic [OP_W-1:0] OP_SQY   = 3'd2;
  localparam logic [OP_W-1:0] OP_TOL   = 3'd3;
  localparam logic [OP_W-1:0] OP_GY    = 3'd4;
  localparam logic [OP_W-1:0] OP_GX    = 3'd5;
  localparam logic [OP_W-1:0] OP_SCALE = 3'd6;
  localparam logic [OP_W-1:0] OP_FIN   = 3'd7;

  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/vas_meas_if.sv]
// ----------------------------------------------------------------------------
// vas_meas_if: measurement request channel
// one control tick: flags, confidence and pixel errors
// ----------------------------------------------------------------------------
`default_nettype none

interface vas_meas_if #(
  parameter int ERR_BITS = vas_pkg::ERR_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic                       restart;
  logic                       fresh;
  logic                       detected;
  logic [7:0]                 confidence;
  logic signed [ERR_BITS-1:0] err_x;
  logic signed [ERR_BITS-1:0] err_y;

  modport source (
    output valid, restart, fresh, detected, confidence, err_x, err_y,
    input  ready
  );
  modport sink (
    input  valid, restart, fresh, detected, confidence, err_x, err_y,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/vas_result_if.sv]
// ----------------------------------------------------------------------------
// vas_result_if: velocity command channel
// one result request per tick: velocities, status and deadband flag
// ----------------------------------------------------------------------------
`default_nettype none

interface vas_result_if ();
  logic                            valid;
  logic                            ready;
  logic signed [vas_pkg::VEL_W-1:0] vel_x;
  logic signed [vas_pkg::VEL_W-1:0] vel_y;
  logic [1:0]                      status;
  logic                            in_deadband;

  modport source (
    output valid, vel_x, vel_y, status, in_deadband,
    input  ready
  );
  modport sink (
    input  valid, vel_x, vel_y, status, in_deadband,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/vas_ctrl.sv]
// ----------------------------------------------------------------------------
// vas_ctrl: step sequencer
// walks one tick through the shared multiplier steps, the scaling step and the final update
// ----------------------------------------------------------------------------
`default_nettype none

module vas_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              valid,
  output logic                   ready,
  input  wire vas_pkg::dp_stat_t stat,
  output vas_pkg::dp_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQX   = 3'd1;
  localparam logic [2:0] S_SQY   = 3'd2;
  localparam logic [2:0] S_TOL   = 3'd3;
  localparam logic [2:0] S_GY    = 3'd4;
  localparam logic [2:0] S_GX    = 3'd5;
  localparam logic [2:0] S_SCALE = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = valid && ready;
    cmd.op     = vas_pkg::OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (valid) state_next = S_SQX;
      end
      S_SQX: begin
        cmd.op     = vas_pkg::OP_SQX;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.op     = vas_pkg::OP_SQY;
        state_next = S_TOL;
      end
      S_TOL: begin
        cmd.op     = vas_pkg::OP_TOL;
        state_next = S_GY;
      end
      S_GY: begin
        cmd.op     = vas_pkg::OP_GY;
        state_next = S_GX;
      end
      S_GX: begin
        cmd.op     = vas_pkg::OP_GX;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.op     = vas_pkg::OP_SCALE;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the result register can take the new request
        if (stat.out_free) begin
          cmd.op     = vas_pkg::OP_FIN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/vas_datapath.sv]
// ----------------------------------------------------------------------------
// vas_datapath: servo arithmetic and timers
// shared multiplier, scaling, clamping, dwell/timeout logic, result register
// ----------------------------------------------------------------------------
`default_nettype none

module vas_datapath #(
  parameter int ERR_BITS   = vas_pkg::ERR_BITS_DEF,
  parameter int TIMER_BITS = vas_pkg::TIMER_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire vas_pkg::dp_cmd_t                 cmd,
  output vas_pkg::dp_stat_t                     stat,
  input  wire logic                             cfg_wr_en,
  input  wire logic [vas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vas_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                             restart,
  input  wire logic                             fresh,
  input  wire logic                             detected,
  input  wire logic [7:0]                       confidence,
  input  wire logic signed [ERR_BITS-1:0]       err_x,
  input  wire logic signed [ERR_BITS-1:0]       err_y,
  vas_result_if.source                          result
);

  localparam int MUL_W  = vas_pkg::CFG_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W   = 2 * ERR_BITS + 1;
  localparam int TOL2_W = 2 * vas_pkg::TOL_W;
  localparam int CMP_W  = (SQ_W > TOL2_W) ? SQ_W : TOL2_W;
  localparam int TCMP_W = (TIMER_BITS > vas_pkg::CFG_W) ? TIMER_BITS : vas_pkg::CFG_W;
  localparam int SPD_W  = vas_pkg::SPD_W;
  localparam int VEL_W  = vas_pkg::VEL_W;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [7:0]            CONF_MIN  = 8'd51;
  localparam logic [14:0]           SPLIT_SQ  = 15'd19600;
  localparam logic [SPD_W-1:0]      NEAR_CAP  = 10'd180;
  localparam logic [SPD_W-1:0]      FAR_CAP   = 10'd350;
  localparam logic [SPD_W-1:0]      Q_SAT     = {SPD_W{1'b1}};

  // gain * 2/5 / 256 rounded: ((m + 320) >> 7) / 5, the /5 by reciprocal 205/1024
  // gain * 3/4 / 256 rounded: (3m + 512) >> 10
  function automatic logic [SPD_W-1:0] scale_mag(input logic [PROD_W-1:0] m,
                                                 input logic near);
    logic [PROD_W:0]   tn;
    logic [PROD_W+1:0] tf;
    logic [17:0]       pr;
    logic [SPD_W-1:0]  r;
    tn = {1'b0, m} + (PROD_W+1)'(320);
    tf = {2'b00, m} + {1'b0, m, 1'b0} + (PROD_W+2)'(512);
    pr = 18'(tn[16:7]) * 18'd205;
    if (near) begin
      if (tn[PROD_W:7] >= (PROD_W-6)'(905)) r = Q_SAT;
      else r = SPD_W'(pr[17:10]);
    end else begin
      if (tf[PROD_W+1:10] > (PROD_W-8)'(1023)) r = Q_SAT;
      else r = tf[19:10];
    end
    return r;
  endfunction

  function automatic logic [ERR_BITS-1:0] mag(input logic [ERR_BITS-1:0] e);
    return e[ERR_BITS-1] ? (~e + ERR_BITS'(1)) : e;
  endfunction

  // configuration
  logic [vas_pkg::TOL_W-1:0] pixel_tolerance;
  logic [vas_pkg::CFG_W-1:0] dwell_ticks;
  logic [vas_pkg::CFG_W-1:0] timeout_ticks;
  logic [vas_pkg::CFG_W-1:0] prop_gain;
  logic [SPD_W-1:0]          speed_limit;

  // timers
  logic [TIMER_BITS-1:0] elapsed_count;
  logic                  dwell_active;
  logic [TIMER_BITS-1:0] dwell_count;

  // latched tick
  logic                tick_restart;
  logic                tick_fresh;
  logic                tick_detected;
  logic [7:0]          tick_conf;
  logic [ERR_BITS-1:0] tick_ex;
  logic [ERR_BITS-1:0] tick_ey;

  // working registers
  logic [PROD_W-1:0] prod;
  logic [SQ_W-1:0]   sq;
  logic [TOL2_W-1:0] tol2;
  logic [PROD_W-1:0] m_fwd;
  logic [SPD_W-1:0]  q_fwd;
  logic [SPD_W-1:0]  q_lat;
  logic              near;
  logic              inband;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  // final update
  logic [TIMER_BITS-1:0] el;
  logic                  da;
  logic [TIMER_BITS-1:0] dc;
  logic [TIMER_BITS-1:0] dc0;
  logic                  timed_out;
  logic [SPD_W-1:0]      cap_c;
  logic [SPD_W-1:0]      cap;
  logic [SPD_W-1:0]      qf_c;
  logic [SPD_W-1:0]      ql_c;
  logic                  ey_pos;
  logic                  ex_pos;
  logic signed [VEL_W-1:0] vx;
  logic signed [VEL_W-1:0] vy;
  logic [1:0]            st;
  logic                  ib;
  logic                  dwell_active_next;
  logic [TIMER_BITS-1:0] dwell_count_next;
  logic [TIMER_BITS-1:0] elapsed_count_next;

  assign stat.out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_tolerance <= vas_pkg::TOL_RST;
      dwell_ticks     <= vas_pkg::DWELL_RST;
      timeout_ticks   <= vas_pkg::TIMEOUT_RST;
      prop_gain       <= vas_pkg::GAIN_RST;
      speed_limit     <= vas_pkg::SPEED_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vas_pkg::REG_TOL:     pixel_tolerance <= cfg_data[vas_pkg::TOL_W-1:0];
        vas_pkg::REG_DWELL:   dwell_ticks     <= cfg_data;
        vas_pkg::REG_TIMEOUT: timeout_ticks   <= cfg_data;
        vas_pkg::REG_GAIN:    prop_gain       <= cfg_data;
        vas_pkg::REG_SPEED:   speed_limit     <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tick_restart  <= restart;
      tick_fresh    <= fresh;
      tick_detected <= detected;
      tick_conf     <= confidence;
      tick_ex       <= err_x;
      tick_ey       <= err_y;
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      vas_pkg::OP_SQX: begin
        mul_a = MUL_W'(mag(tick_ex));
        mul_b = MUL_W'(mag(tick_ex));
      end
      vas_pkg::OP_SQY: begin
        mul_a = MUL_W'(mag(tick_ey));
        mul_b = MUL_W'(mag(tick_ey));
      end
      vas_pkg::OP_TOL: begin
        mul_a = MUL_W'(pixel_tolerance);
        mul_b = MUL_W'(pixel_tolerance);
      end
      vas_pkg::OP_GY: begin
        mul_a = MUL_W'(mag(tick_ey));
        mul_b = prop_gain;
      end
      vas_pkg::OP_GX: begin
        mul_a = MUL_W'(mag(tick_ex));
        mul_b = prop_gain;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    case (cmd.op)
      vas_pkg::OP_SQX: prod <= mul_p;
      vas_pkg::OP_SQY: begin
        sq   <= SQ_W'(prod);
        prod <= mul_p;
      end
      vas_pkg::OP_TOL: begin
        sq   <= sq + SQ_W'(prod);
        prod <= mul_p;
      end
      vas_pkg::OP_GY: begin
        tol2 <= prod[TOL2_W-1:0];
        prod <= mul_p;
      end
      vas_pkg::OP_GX: begin
        m_fwd <= prod;
        prod  <= mul_p;
      end
      vas_pkg::OP_SCALE: begin
        near   <= CMP_W'(sq) < CMP_W'(SPLIT_SQ);
        inband <= CMP_W'(sq) <= CMP_W'(tol2);
        q_fwd  <= scale_mag(m_fwd, CMP_W'(sq) < CMP_W'(SPLIT_SQ));
        q_lat  <= scale_mag(prod, CMP_W'(sq) < CMP_W'(SPLIT_SQ));
      end
      default: ;
    endcase
  end

  always_comb begin
    el        = tick_restart ? '0 : elapsed_count;
    da        = tick_restart ? 1'b0 : dwell_active;
    dc        = tick_restart ? '0 : dwell_count;
    dc0       = da ? dc : '0;
    timed_out = TCMP_W'(el) > TCMP_W'(timeout_ticks);

    cap_c = near ? NEAR_CAP : FAR_CAP;
    cap   = (speed_limit < cap_c) ? speed_limit : cap_c;
    qf_c  = (q_fwd > cap) ? cap : q_fwd;
    ql_c  = (q_lat > cap) ? cap : q_lat;
    ey_pos = !tick_ey[ERR_BITS-1] && (tick_ey != '0);
    ex_pos = !tick_ex[ERR_BITS-1] && (tick_ex != '0);

    vx = '0;
    vy = '0;
    st = vas_pkg::ST_RUN;
    ib = 1'b0;
    dwell_active_next = 1'b0;
    dwell_count_next  = '0;

    if (!tick_fresh) begin
      if (timed_out) st = vas_pkg::ST_FAIL;
    end else if (!tick_detected || (tick_conf < CONF_MIN)) begin
      // lost target: no timeout check
      st = vas_pkg::ST_RUN;
    end else if (inband) begin
      ib = 1'b1;
      dwell_active_next = 1'b1;
      if (TCMP_W'(dc0) >= TCMP_W'(dwell_ticks)) begin
        st = vas_pkg::ST_OK;
        dwell_count_next = dc0;
      end else begin
        dwell_count_next = (dc0 == TIMER_MAX) ? dc0 : dc0 + TIMER_BITS'(1);
        if (timed_out) st = vas_pkg::ST_FAIL;
      end
    end else if (timed_out) begin
      st = vas_pkg::ST_FAIL;
    end else begin
      vx = ey_pos ? -$signed(VEL_W'(qf_c)) : $signed(VEL_W'(qf_c));
      vy = ex_pos ? -$signed(VEL_W'(ql_c)) : $signed(VEL_W'(ql_c));
    end

    elapsed_count_next = (el == TIMER_MAX) ? el : el + TIMER_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_count <= '0;
      dwell_active  <= 1'b0;
      dwell_count   <= '0;
    end else if (cmd.op == vas_pkg::OP_FIN) begin
      elapsed_count <= elapsed_count_next;
      dwell_active  <= dwell_active_next;
      dwell_count   <= dwell_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.op == vas_pkg::OP_FIN) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == vas_pkg::OP_FIN) begin
      result.vel_x       <= vx;
      result.vel_y       <= vy;
      result.status      <= st;
      result.in_deadband <= ib;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/visual_align_servo.sv]
// ----------------------------------------------------------------------------
// visual_align_servo: proportional visual servo with deadband and dwell
// turns per-tick pixel errors into crossed, negated velocity commands
// ----------------------------------------------------------------------------
//
//  channel   kind              direction  contents
//  meas      valid/ready       in         restart, fresh, detected, confidence,
//                                         err_x, err_y
//  result    valid/ready       out        vel_x, vel_y, status, in_deadband
//  cfg       write strobe      in         cfg_wr_en, cfg_index, cfg_data
//
//  one tick passes through the accept step, five steps on the single shared
//  16x16 multiplier (two squares, tolerance squared, two gain products), a
//  scaling step and a final timer/result update
//  the result register parts the two sides: the next tick is taken and worked
//  on while the previous result waits; only the final step waits for a free
//  result register
//  synchronous reset loads the register reset values, clears the timers and
//  empties the result register
//
`default_nettype none

module visual_align_servo #(
  parameter int ERR_BITS   = vas_pkg::ERR_BITS_DEF,
  parameter int TIMER_BITS = vas_pkg::TIMER_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  vas_meas_if.sink                           meas,
  vas_result_if.source                       result,
  input  wire logic                          cfg_wr_en,
  input  wire logic [vas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vas_pkg::CFG_W-1:0]     cfg_data
);

  // sequencer to datapath commands and back
  vas_pkg::dp_cmd_t  cmd;
  vas_pkg::dp_stat_t stat;
  logic              ctl_ready;

  // a request is taken only while the sequencer is idle
  assign meas.ready = ctl_ready;

  vas_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (meas.valid),
    .ready (ctl_ready),
    .stat  (stat),
    .cmd   (cmd)
  );

  // arithmetic, timers, configuration and the result register
  vas_datapath #(
    .ERR_BITS   (ERR_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .restart    (meas.restart),
    .fresh      (meas.fresh),
    .detected   (meas.detected),
    .confidence (meas.confidence),
    .err_x      (meas.err_x),
    .err_y      (meas.err_y),
    .result     (result)
  );

`ifndef SYNTHESIS
  // the final step always leaves a result request behind
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == vas_pkg::OP_FIN) |=> result.valid)
    else $error("final step did not load the result register");

  // a new tick is never taken while an earlier one is still in the datapath
  assert property (@(posedge clk) disable iff (rst)
    meas.ready |-> (cmd.op == vas_pkg::OP_IDLE))
    else $error("input accepted while a step is in progress");

  // inside the deadband the command is always a stop
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.in_deadband) |-> (result.vel_x == '0 && result.vel_y == '0))
    else $error("non-zero velocity inside the deadband");

  // status carries only the three defined codes
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.status == vas_pkg::ST_RUN ||
                      result.status == vas_pkg::ST_OK ||
                      result.status == vas_pkg::ST_FAIL))
    else $error("undefined status code");
`endif

endmodule

`default_nettype wire

[sim/vas_command_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vas_command_check: velocity command checker for the visual alignment servo
// mirrors the register writes, predicts one command per accepted measurement
// and compares every accepted result with the oldest prediction
// ----------------------------------------------------------------------------

module vas_command_check (
  input  logic                          clk,
  input  logic                          rst,
  vas_meas_if                           meas,
  vas_result_if                         result,
  input  logic                          cfg_wr_en,
  input  logic [vas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vas_pkg::CFG_W-1:0]     cfg_data,
  output int                            pending,
  output int                            failures
);
  import vas_pkg::*;

  localparam int EW      = ERR_BITS_DEF;
  localparam int TIMER_W = TIMER_BITS_DEF;
  localparam int REPORT_MAX = 10;

  localparam logic [7:0]         CONF_FLOOR = 8'd51;
  localparam longint             SPLIT_SQ   = 19600;
  localparam longint             NEAR_CAP   = 180;
  localparam longint             FAR_CAP    = 350;
  localparam longint             NEAR_NUM   = 2;
  localparam longint             NEAR_DEN   = 5;
  localparam longint             FAR_NUM    = 3;
  localparam longint             FAR_DEN    = 4;
  localparam logic [TIMER_W-1:0] TIMER_TOP  = '1;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic [1:0]              status;
    logic                    in_deadband;
  } servo_cmd_t;

  // register copies
  logic [TOL_W-1:0] cfg_tol;
  logic [CFG_W-1:0] cfg_dwell;
  logic [CFG_W-1:0] cfg_timeout;
  logic [CFG_W-1:0] cfg_gain;
  logic [SPD_W-1:0] cfg_speed;

  // servo timers
  logic [TIMER_W-1:0] elapsed_ticks;
  logic [TIMER_W-1:0] dwell_ticks_seen;
  logic               dwell_on;

  servo_cmd_t command_q[$];
  int         errors;

  // proportional drive of one axis, magnitude rounded half away from zero
  function automatic logic signed [VEL_W-1:0] drive_axis(input longint e, input logic near,
                                                         input longint cap);
    longint mag;
    longint div;
    longint q;
    longint v;
    mag = (e < 0 ? -e : e) * longint'(cfg_gain) * (near ? NEAR_NUM : FAR_NUM);
    div = (near ? NEAR_DEN : FAR_DEN) * 256;
    q   = (mag + div / 2) / div;
    if (q > cap) q = cap;
    v = (e > 0) ? -q : q;
    return v[VEL_W-1:0];
  endfunction

  function automatic servo_cmd_t servo_tick(input logic restart, input logic fresh,
                                            input logic detected, input logic [7:0] conf,
                                            input logic signed [EW-1:0] ex_in,
                                            input logic signed [EW-1:0] ey_in);
    servo_cmd_t c;
    logic       late;
    logic       near;
    longint     ex;
    longint     ey;
    longint     sq;
    longint     cap;
    c = '0;
    c.status = ST_RUN;
    if (restart) begin
      elapsed_ticks    = '0;
      dwell_ticks_seen = '0;
      dwell_on         = 1'b0;
    end
    late = elapsed_ticks > cfg_timeout;
    if (!fresh) begin
      dwell_on         = 1'b0;
      dwell_ticks_seen = '0;
      if (late) c.status = ST_FAIL;
    end else if (!detected || conf < CONF_FLOOR) begin
      // target lost: no timeout check here
      dwell_on         = 1'b0;
      dwell_ticks_seen = '0;
    end else begin
      ex = ex_in;
      ey = ey_in;
      sq = ex * ex + ey * ey;
      if (sq <= longint'(cfg_tol) * longint'(cfg_tol)) begin
        c.in_deadband = 1'b1;
        if (!dwell_on) begin
          dwell_on         = 1'b1;
          dwell_ticks_seen = '0;
        end
        if (dwell_ticks_seen >= cfg_dwell) begin
          c.status = ST_OK;
        end else begin
          if (dwell_ticks_seen != TIMER_TOP) dwell_ticks_seen = dwell_ticks_seen + 1'b1;
          if (late) c.status = ST_FAIL;
        end
      end else begin
        near             = sq < SPLIT_SQ;
        dwell_on         = 1'b0;
        dwell_ticks_seen = '0;
        cap = near ? NEAR_CAP : FAR_CAP;
        if (longint'(cfg_speed) < cap) cap = longint'(cfg_speed);
        if (late) begin
          c.status = ST_FAIL;
        end else begin
          // crossed axes
          c.vel_x = drive_axis(ey, near, cap);
          c.vel_y = drive_axis(ex, near, cap);
        end
      end
    end
    if (elapsed_ticks != TIMER_TOP) elapsed_ticks = elapsed_ticks + 1'b1;
    return c;
  endfunction

  always @(posedge clk) begin
    servo_cmd_t want;
    servo_cmd_t got;
    if (rst) begin
      cfg_tol          = TOL_RST;
      cfg_dwell        = DWELL_RST;
      cfg_timeout      = TIMEOUT_RST;
      cfg_gain         = GAIN_RST;
      cfg_speed        = SPEED_RST;
      elapsed_ticks    = '0;
      dwell_ticks_seen = '0;
      dwell_on         = 1'b0;
      command_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TOL:     cfg_tol     = cfg_data[TOL_W-1:0];
          REG_DWELL:   cfg_dwell   = cfg_data;
          REG_TIMEOUT: cfg_timeout = cfg_data;
          REG_GAIN:    cfg_gain    = cfg_data;
          REG_SPEED:   cfg_speed   = cfg_data[SPD_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        got.vel_x       = result.vel_x;
        got.vel_y       = result.vel_y;
        got.status      = result.status;
        got.in_deadband = result.in_deadband;
        if (command_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t vas_command_check: unexpected result vx=%0d vy=%0d st=%0d db=%0d",
                     $realtime, got.vel_x, got.vel_y, got.status, got.in_deadband);
        end else begin
          want = command_q.pop_front();
          if (got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
              got.status !== want.status || got.in_deadband !== want.in_deadband) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t vas_command_check: mismatch exp vx=%0d vy=%0d st=%0d db=%0d %s",
                       $realtime, want.vel_x, want.vel_y, want.status, want.in_deadband,
                       $sformatf("got vx=%0d vy=%0d st=%0d db=%0d", got.vel_x, got.vel_y,
                                 got.status, got.in_deadband));
          end
        end
      end
      if (meas.valid && meas.ready)
        command_q.push_back(servo_tick(meas.restart, meas.fresh, meas.detected,
                                       meas.confidence, meas.err_x, meas.err_y));
    end
    pending  <= command_q.size();
    failures <= errors;
  end

  initial begin
    errors   = 0;
    pending  = 0;
    failures = 0;
  end

endmodule

[sim/tb_visual_align_servo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_visual_align_servo: testbench top for the visual alignment servo
// drives measurement requests and register settings, stalls the result side
// and leaves prediction and comparison to vas_command_check
// ----------------------------------------------------------------------------

module tb_visual_align_servo;
  import vas_pkg::*;

  localparam int ERR_W         = ERR_BITS_DEF;
  localparam int ERR_MAX       = 2 ** (ERR_W - 1) - 1;
  localparam int ERR_MIN       = -(2 ** (ERR_W - 1));
  localparam int RESET_CYCLES  = 10;
  localparam int STALL_LIMIT   = 2000;   // cycles with no request moving
  localparam int SETTLE_CYCLES = 24;     // wait before the final verdict
  localparam int PHASES        = 8;
  localparam int PHASE_TICKS   = 85;
  localparam int NUM_REGS      = 5;

  // one measurement request
  typedef struct packed {
    logic                    restart;
    logic                    fresh;
    logic                    detected;
    logic [7:0]              confidence;
    logic signed [ERR_W-1:0] err_x;
    logic signed [ERR_W-1:0] err_y;
  } meas_tick_t;

  // one full register setting
  typedef struct {
    logic [TOL_W-1:0] tol;
    logic [CFG_W-1:0] dwell;
    logic [CFG_W-1:0] timeout;
    logic [CFG_W-1:0] gain;
    logic [SPD_W-1:0] speed;
  } servo_cfg_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int pending;        // commands predicted but not yet seen
  int fail_count;
  int idle_cycles;
  int stall_left;
  bit steady;         // no new pauses on either side while set

  // approach episode state for the random part
  int ep_left;
  int aim_x;
  int aim_y;

  vas_meas_if #(.ERR_BITS(ERR_W)) meas ();
  vas_result_if                   result ();

  visual_align_servo #(
    .ERR_BITS   (ERR_W),
    .TIMER_BITS (TIMER_BITS_DEF)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .meas      (meas),
    .result    (result),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vas_command_check check (
    .clk       (clk),
    .rst       (rst),
    .meas      (meas),
    .result    (result),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .failures  (fail_count)
  );

  // 4 ns clock
  always #2 clk = ~clk;

  // mostly short pauses, now and then a long one
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ERR_W-1:0] clip_err(input int v);
    if (v > ERR_MAX) v = ERR_MAX;
    if (v < ERR_MIN) v = ERR_MIN;
    return v[ERR_W-1:0];
  endfunction

  function automatic meas_tick_t mk(input int restart, input int fresh,
                                    input int detected, input int conf,
                                    input int ex, input int ey);
    meas_tick_t t;
    t.restart    = restart[0];
    t.fresh      = fresh[0];
    t.detected   = detected[0];
    t.confidence = conf[7:0];
    t.err_x      = clip_err(ex);
    t.err_y      = clip_err(ey);
    return t;
  endfunction

  // random request: mostly an approach that shrinks the error towards the
  // centre and then sits in the deadband, with stale, lost and raw noise mixed in
  function automatic meas_tick_t next_tick();
    meas_tick_t t;
    int         pick;
    int         jx;
    int         jy;
    logic       start;
    start = 1'b0;
    if (ep_left == 0) begin
      // an occasional long episode so the timeout is reached
      ep_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 300) : $urandom_range(8, 80);
      aim_x   = $urandom_range(0, 2 ** ERR_W - 1) + ERR_MIN;
      aim_y   = $urandom_range(0, 2 ** ERR_W - 1) + ERR_MIN;
      start   = 1'b1;
    end
    ep_left--;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // raw noise, every bit free but restart, which comes only now and then
      t.restart    = start | ($urandom_range(0, 15) == 0);
      t.fresh      = 1'($urandom_range(0, 1));
      t.detected   = 1'($urandom_range(0, 1));
      t.confidence = 8'($urandom_range(0, 255));
      t.err_x      = ERR_W'($urandom);
      t.err_y      = ERR_W'($urandom);
      return t;
    end
    jx = $urandom_range(0, 1) ? $urandom_range(0, 6) - 3 : 0;
    jy = $urandom_range(0, 1) ? $urandom_range(0, 6) - 3 : 0;
    t.restart    = start;
    t.fresh      = pick >= 21;
    t.detected   = !(pick >= 21 && pick < 25);
    t.confidence = (pick >= 25 && pick < 29) ? 8'($urandom_range(0, 50))
                                             : 8'($urandom_range(51, 255));
    t.err_x      = clip_err(aim_x + jx);
    t.err_y      = clip_err(aim_y + jy);
    aim_x = aim_x * 2 / 3;
    aim_y = aim_y * 2 / 3;
    return t;
  endfunction

  // one register per falling edge, strobe dropped after the last
  task automatic write_settings(input servo_cfg_t c);
    logic [CFG_IDX_W-1:0] regs [NUM_REGS];
    logic [CFG_W-1:0]     vals [NUM_REGS];
    regs[0] = REG_TOL;     vals[0] = CFG_W'(c.tol);
    regs[1] = REG_DWELL;   vals[1] = c.dwell;
    regs[2] = REG_TIMEOUT; vals[2] = c.timeout;
    regs[3] = REG_GAIN;    vals[3] = c.gain;
    regs[4] = REG_SPEED;   vals[4] = CFG_W'(c.speed);
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // present one request, optionally after a gap, and hold it until taken
  task automatic send_tick(input meas_tick_t t);
    int gap;
    gap = steady ? 0 : pick_pause();
    @(negedge clk);
    if (gap != 0) begin
      meas.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    meas.valid      <= 1'b1;
    meas.restart    <= t.restart;
    meas.fresh      <= t.fresh;
    meas.detected   <= t.detected;
    meas.confidence <= t.confidence;
    meas.err_x      <= t.err_x;
    meas.err_y      <= t.err_y;
    do @(posedge clk); while (!meas.ready);
  endtask

  // sender holds off until every predicted command has come back
  task automatic drain_results();
    @(negedge clk);
    meas.valid <= 1'b0;
    wait (pending == 0);
  endtask

  // result side: random back-pressure, no new stall started while steady
  initial begin
    result.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        result.ready <= 1'b0;
        stall_left--;
      end else begin
        result.ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_pause();
      end
    end
  end

  // watchdog: too long with no request moving on either channel
  always @(posedge clk) begin
    if (rst || (meas.valid && meas.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_visual_align_servo: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    meas_tick_t directed[$];
    servo_cfg_t c;

    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_index       = REG_TOL;
    cfg_data        = '0;
    meas.valid      = 1'b0;
    meas.restart    = 1'b0;
    meas.fresh      = 1'b0;
    meas.detected   = 1'b0;
    meas.confidence = '0;
    meas.err_x      = '0;
    meas.err_y      = '0;
    idle_cycles     = 0;
    steady          = 1'b0;
    ep_left         = 0;
    aim_x           = 0;
    aim_y           = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part: short dwell and timeout so both are reached quickly
    c.tol = 11'd25; c.dwell = 16'd2; c.timeout = 16'd12; c.gain = 16'd256; c.speed = 10'd350;
    write_settings(c);

    directed.push_back(mk(1, 1, 1, 255, 0, 0));          // restart, dwell begins
    directed.push_back(mk(0, 1, 1, 200, 3, -4));         // still inside
    directed.push_back(mk(0, 1, 1, 200, 25, 0));         // on the tolerance edge, dwell met
    directed.push_back(mk(0, 1, 1, 51, 25, 1));          // just outside, near gain
    directed.push_back(mk(0, 1, 1, 128, 150, -150));     // far, rounds a half away from zero
    directed.push_back(mk(0, 1, 1, 128, 139, 0));        // last near point
    directed.push_back(mk(0, 1, 1, 128, 140, 0));        // first far point
    directed.push_back(mk(0, 1, 1, 255, ERR_MIN, ERR_MAX));  // extremes, capped
    directed.push_back(mk(0, 1, 1, 255, ERR_MAX, ERR_MIN));
    directed.push_back(mk(0, 0, 1, 255, 5, 5));          // stale sample
    directed.push_back(mk(0, 1, 0, 255, 5, 5));          // not detected
    directed.push_back(mk(0, 1, 1, 50, 5, 5));           // confidence just too low
    directed.push_back(mk(0, 1, 1, 51, -1, -1));         // lowest accepted confidence
    directed.push_back(mk(0, 1, 1, 90, 0, 1));           // timed out inside the deadband
    directed.push_back(mk(0, 1, 1, 90, 0, 0));           // dwell met wins over timeout
    directed.push_back(mk(0, 0, 1, 90, 0, 0));           // stale after timeout
    directed.push_back(mk(0, 1, 0, 90, 0, 0));           // lost after timeout: no failure
    directed.push_back(mk(0, 1, 1, 90, -500, 300));      // timed out outside: zero command
    directed.push_back(mk(0, 1, 1, 90, 50, -60));
    directed.push_back(mk(1, 1, 1, 90, 100, 100));       // restart clears the timeout
    directed.push_back(mk(0, 1, 1, 90, -7, 0));
    directed.push_back(mk(0, 1, 1, 255, 0, ERR_MIN));
    directed.push_back(mk(1, 0, 0, 0, 0, 0));            // restart on a stale sample
    directed.push_back(mk(0, 1, 1, 255, -150, 150));
    foreach (directed[i]) send_tick(directed[i]);
    drain_results();

    // random part over several register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          c.tol = TOL_RST; c.dwell = DWELL_RST; c.timeout = TIMEOUT_RST;
          c.gain = GAIN_RST; c.speed = SPEED_RST;
        end
        1: begin
          c.tol = '0; c.dwell = '0; c.timeout = '0; c.gain = '0; c.speed = '0;
        end
        2: begin
          c.tol = '1; c.dwell = '1; c.timeout = '1; c.gain = '1; c.speed = 10'd1000;
        end
        default: begin
          c.tol     = ($urandom_range(0, 5) == 0) ? TOL_W'($urandom_range(0, 2047))
                                                  : TOL_W'($urandom_range(0, 60));
          c.dwell   = CFG_W'($urandom_range(0, 25));
          c.timeout = CFG_W'($urandom_range(10, 200));
          c.gain    = $urandom_range(0, 1) ? CFG_W'($urandom_range(0, 65535))
                                           : CFG_W'($urandom_range(64, 1024));
          c.speed   = SPD_W'($urandom_range(0, 1000));
        end
      endcase
      write_settings(c);
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        // now and then the sender waits for everything to come back
        if ($urandom_range(0, 99) == 0) drain_results();
        send_tick(next_tick());
      end
      steady = 1'b0;
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_visual_align_servo: done, clean");
    end else begin
      $display("tb_visual_align_servo: done, errors");
    end
    $finish;
  end

endmodule
